[design/psq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psq_pkg
// shared constants and the data type handed along the degree cells
// ---------------------------------------------------------------------------
package psq_pkg;

    localparam int NOTE_RANGE_DEF  = 120;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int NUM_DEG  = 12;
    localparam int FRAC_W   = 8;
    localparam int NOTE_W   = 7;
    localparam int NQ8_W    = NOTE_W + FRAC_W;
    localparam int DEG_W    = 4;
    localparam int OCT_W    = 4;
    localparam int MAX_OCT  = ((1 << NOTE_W) - 1) / NUM_DEG;
    localparam int OCT_Q8   = NUM_DEG << FRAC_W;
    localparam int R_W      = DEG_W + FRAC_W;
    localparam int DIST_W   = 14;
    localparam int DIST_INIT = 40 << FRAC_W;
    localparam int CAND_W   = 9;

    typedef struct packed {
        logic [NOTE_W-1:0]        base;
        logic [R_W-1:0]           rem;
        logic [DIST_W-1:0]        best_dist;
        logic signed [CAND_W-1:0] best_note;
    } t_cell_data;

endpackage
`default_nettype wire

[design/pitch_scale_quantizer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pitch_scale_quantizer_unit
// snaps a control voltage sample to the nearest pitch class in a scale mask
// ---------------------------------------------------------------------------
// usage
// input item: one signed sample on i_in_sample with i_valid, held while
//   o_stall is high. output item: o_out_sample, o_quant_note, o_quantized
//   with o_valid, held while i_stall is high.
// i_scale_mask is written when i_scale_mask_we is high; write it only with
//   no item in flight. bit i enables pitch class i. an empty mask passes the
//   sample through with note 0 and quantized low.
// stages: two front stages (scaling multiply, octave split), twelve degree
//   cells, one output stage. one item is taken every cycle while o_stall is
//   low; every stage is a register with its own valid, so bubbles close up.
// when the receiver stalls, the stall passes back combinationally through the
//   stages that hold an item, and o_stall rises only once every stage holds one.
// reset clears all stage valids and the mask; there is no start-up sweep.
// ---------------------------------------------------------------------------
module pitch_scale_quantizer_unit #(
    parameter int NOTE_RANGE  = psq_pkg::NOTE_RANGE_DEF,
    parameter int SAMPLE_BITS = psq_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_scale_mask_we,
    input  wire logic [psq_pkg::NUM_DEG-1:0]   i_scale_mask,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_in_sample,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_out_sample,
    output logic [psq_pkg::NOTE_W-1:0]         o_quant_note,
    output logic                               o_quantized
);

    localparam int NC = psq_pkg::NUM_DEG;

    logic [NC-1:0]            r_mask;

    logic                     w_vld   [NC+1];
    logic                     w_stall [NC+1];
    logic [SAMPLE_BITS-1:0]   w_smp   [NC+1];
    psq_pkg::t_cell_data      w_data  [NC+1];
    logic [SAMPLE_BITS-1:0]   w_out_smp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_scale_mask_we) begin
            r_mask <= i_scale_mask;
        end
    end

    psq_front #(
        .NOTE_RANGE  (NOTE_RANGE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_in_sample),
        .o_valid  (w_vld[0]),
        .i_stall  (w_stall[0]),
        .o_sample (w_smp[0]),
        .o_data   (w_data[0])
    );

    for (genvar g = 0; g < NC; g++) begin : g_cell
        psq_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .DEG         (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_enable (r_mask[g]),
            .i_valid  (w_vld[g]),
            .o_stall  (w_stall[g]),
            .i_sample (w_smp[g]),
            .i_data   (w_data[g]),
            .o_valid  (w_vld[g+1]),
            .i_stall  (w_stall[g+1]),
            .o_sample (w_smp[g+1]),
            .o_data   (w_data[g+1])
        );
    end

    psq_back #(
        .NOTE_RANGE  (NOTE_RANGE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mask_any  (|r_mask),
        .i_valid     (w_vld[NC]),
        .o_stall     (w_stall[NC]),
        .i_sample    (w_smp[NC]),
        .i_data      (w_data[NC]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sample    (w_out_smp),
        .o_note      (o_quant_note),
        .o_quantized (o_quantized)
    );

    assign o_out_sample = $signed(w_out_smp);

endmodule
`default_nettype wire

[design/psq_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psq_front
// sample to UQ7.8 note, then split into octave base and offset within octave
// ---------------------------------------------------------------------------
module psq_front #(
    parameter int NOTE_RANGE  = psq_pkg::NOTE_RANGE_DEF,
    parameter int SAMPLE_BITS = psq_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [SAMPLE_BITS-1:0]      o_sample,
    output psq_pkg::t_cell_data         o_data
);

    localparam int PROD_W = SAMPLE_BITS + psq_pkg::NOTE_W;

    logic                              r_a_vld;
    logic [SAMPLE_BITS-1:0]            r_a_smp;
    logic [psq_pkg::NQ8_W-1:0]         r_a_nq8;
    logic                              r_b_vld;
    logic [SAMPLE_BITS-1:0]            r_b_smp;
    psq_pkg::t_cell_data               r_b_data;

    logic                              w_b_stall;
    logic [SAMPLE_BITS-1:0]            w_u;
    logic [PROD_W-1:0]                 w_prod;
    psq_pkg::t_cell_data               n_b_data;

    // offset binary, then scale onto the note range
    assign w_u    = {~i_sample[SAMPLE_BITS-1], i_sample[SAMPLE_BITS-2:0]};
    assign w_prod = PROD_W'(w_u) * PROD_W'(NOTE_RANGE);

    assign w_b_stall = r_b_vld && i_stall;
    assign o_stall   = r_a_vld && w_b_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_a_vld <= i_valid;
            end
            if (!w_b_stall) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_a_smp <= i_sample;
            r_a_nq8 <= w_prod[SAMPLE_BITS-psq_pkg::FRAC_W +: psq_pkg::NQ8_W];
        end
        if (r_a_vld && !w_b_stall) begin
            r_b_smp  <= r_a_smp;
            r_b_data <= n_b_data;
        end
    end

    always_comb begin
        logic [psq_pkg::NOTE_W-1:0] semi;
        logic [psq_pkg::NOTE_W-1:0] base;
        logic [psq_pkg::NOTE_W-1:0] deg_pos;
        semi = r_a_nq8[psq_pkg::NQ8_W-1:psq_pkg::FRAC_W];
        base = '0;
        for (int k = 1; k <= psq_pkg::MAX_OCT; k++) begin
            if (semi >= psq_pkg::NOTE_W'(psq_pkg::NUM_DEG * k)) begin
                base = psq_pkg::NOTE_W'(psq_pkg::NUM_DEG * k);
            end
        end
        deg_pos            = semi - base;
        n_b_data.base      = base;
        n_b_data.rem       = {deg_pos[psq_pkg::DEG_W-1:0],
                              r_a_nq8[psq_pkg::FRAC_W-1:0]};
        n_b_data.best_dist = psq_pkg::DIST_W'(psq_pkg::DIST_INIT);
        n_b_data.best_note = '0;
    end

    assign o_valid  = r_b_vld;
    assign o_sample = r_b_smp;
    assign o_data   = r_b_data;

endmodule
`default_nettype wire

[design/psq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psq_cell
// one scale degree: distance with octave wrap, keeps the nearest so far
// ---------------------------------------------------------------------------
module psq_cell #(
    parameter int SAMPLE_BITS = psq_pkg::SAMPLE_BITS_DEF,
    parameter int DEG         = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_enable,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire psq_pkg::t_cell_data    i_data,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [SAMPLE_BITS-1:0]      o_sample,
    output psq_pkg::t_cell_data         o_data
);

    localparam logic signed [psq_pkg::DIST_W-1:0] DEG_Q8 =
        psq_pkg::DIST_W'(DEG << psq_pkg::FRAC_W);
    localparam logic signed [psq_pkg::DIST_W-1:0] OCT_Q8 =
        psq_pkg::DIST_W'(psq_pkg::OCT_Q8);
    localparam logic signed [psq_pkg::CAND_W-1:0] ADJ_UP =
        psq_pkg::CAND_W'(psq_pkg::NUM_DEG);
    localparam logic signed [psq_pkg::CAND_W-1:0] ADJ_DN = -ADJ_UP;
    localparam logic signed [psq_pkg::CAND_W-1:0] DEG_C  = psq_pkg::CAND_W'(DEG);

    logic                   r_vld;
    logic [SAMPLE_BITS-1:0] r_smp;
    psq_pkg::t_cell_data    r_data;

    logic signed [psq_pkg::DIST_W-1:0] w_d;
    logic signed [psq_pkg::DIST_W-1:0] w_alt;
    logic [psq_pkg::DIST_W-1:0]        w_ad;
    logic [psq_pkg::DIST_W-1:0]        w_aa;
    logic                              w_take_alt;
    logic [psq_pkg::DIST_W-1:0]        w_dist;
    logic signed [psq_pkg::CAND_W-1:0] w_adj;
    logic signed [psq_pkg::CAND_W-1:0] w_cand;
    psq_pkg::t_cell_data               n_data;

    assign w_d   = DEG_Q8 - $signed({2'b00, i_data.rem});
    assign w_alt = (w_d > 0) ? (w_d - OCT_Q8) : (w_d + OCT_Q8);
    assign w_ad  = w_d[psq_pkg::DIST_W-1] ? -w_d : w_d;
    assign w_aa  = w_alt[psq_pkg::DIST_W-1] ? -w_alt : w_alt;

    // equal magnitudes go the wrapped way
    assign w_take_alt = (w_aa <= w_ad);
    assign w_dist     = w_take_alt ? w_aa : w_ad;
    assign w_adj      = !w_take_alt ? '0 : ((w_d > 0) ? ADJ_DN : ADJ_UP);
    assign w_cand     = $signed({2'b00, i_data.base}) + DEG_C + w_adj;

    always_comb begin
        n_data = i_data;
        if (i_enable && (w_dist < i_data.best_dist)) begin
            n_data.best_dist = w_dist;
            n_data.best_note = w_cand;
        end
    end

    assign o_stall = r_vld && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_smp  <= i_sample;
            r_data <= n_data;
        end
    end

    assign o_valid  = r_vld;
    assign o_sample = r_smp;
    assign o_data   = r_data;

endmodule
`default_nettype wire

[design/psq_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psq_back
// clamp the chosen note, map it to a sample or pass through, output register
// ---------------------------------------------------------------------------
module psq_back #(
    parameter int NOTE_RANGE  = psq_pkg::NOTE_RANGE_DEF,
    parameter int SAMPLE_BITS = psq_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_mask_any,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire psq_pkg::t_cell_data    i_data,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [SAMPLE_BITS-1:0]      o_sample,
    output logic [psq_pkg::NOTE_W-1:0]  o_note,
    output logic                        o_quantized
);

    localparam int TAB_N = 1 << psq_pkg::NOTE_W;
    localparam logic [SAMPLE_BITS-1:0] SMP_HALF = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [psq_pkg::CAND_W-1:0] RANGE_C =
        psq_pkg::CAND_W'(NOTE_RANGE);

    logic                          r_vld;
    logic [SAMPLE_BITS-1:0]        r_smp;
    logic [psq_pkg::NOTE_W-1:0]    r_note;
    logic                          r_quant;

    logic [SAMPLE_BITS-1:0]        w_tab [TAB_N];
    logic [psq_pkg::NOTE_W-1:0]    w_note;
    logic [SAMPLE_BITS-1:0]        n_smp;
    logic [psq_pkg::NOTE_W-1:0]    n_note;

    // note to sample table, top of range saturates
    for (genvar n = 0; n < TAB_N; n++) begin : g_tab
        localparam logic [63:0] QV = (64'(n) << SAMPLE_BITS) / NOTE_RANGE;
        localparam logic [SAMPLE_BITS-1:0] TV =
            (n >= NOTE_RANGE) ? SMP_MAX : (QV[SAMPLE_BITS-1:0] ^ SMP_HALF);
        assign w_tab[n] = TV;
    end

    always_comb begin
        if (i_data.best_note[psq_pkg::CAND_W-1]) begin
            w_note = '0;
        end else if (i_data.best_note > RANGE_C) begin
            w_note = psq_pkg::NOTE_W'(NOTE_RANGE);
        end else begin
            w_note = i_data.best_note[psq_pkg::NOTE_W-1:0];
        end
    end

    assign n_smp  = i_mask_any ? w_tab[w_note] : i_sample;
    assign n_note = i_mask_any ? w_note : '0;

    assign o_stall = r_vld && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_smp   <= n_smp;
            r_note  <= n_note;
            r_quant <= i_mask_any;
        end
    end

    assign o_valid     = r_vld;
    assign o_sample    = r_smp;
    assign o_note      = r_note;
    assign o_quantized = r_quant;

endmodule
`default_nettype wire

[design/psq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psq_checker
// port level checks on the quantizer, bound to the top level
// ---------------------------------------------------------------------------
module psq_checker #(
    parameter int NOTE_RANGE  = psq_pkg::NOTE_RANGE_DEF,
    parameter int SAMPLE_BITS = psq_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic signed [SAMPLE_BITS-1:0] o_out_sample,
    input wire logic [psq_pkg::NOTE_W-1:0]    o_quant_note,
    input wire logic                          o_quantized
);

    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_sample)
            && $stable(o_quant_note) && $stable(o_quantized))
        else $error("output item changed under stall");

    a_note_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quant_note <= psq_pkg::NOTE_W'(NOTE_RANGE)))
        else $error("note above range");

    a_pass_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_quantized |-> (o_quant_note == '0))
        else $error("pass-through item with nonzero note");

    // lowest note maps to the most negative sample
    a_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_quantized && (o_quant_note == '0)
            |-> (o_out_sample == $signed(SMP_MIN)))
        else $error("note zero with wrong sample");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind pitch_scale_quantizer_unit psq_checker #(
    .NOTE_RANGE  (NOTE_RANGE),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_psq_checker (.*);
`default_nettype wire
